### src/sliding_window_hit_counter_macros.svh
// Assertion macros for the sliding window hit counter checker.
`ifndef SLIDING_WINDOW_HIT_COUNTER_MACROS_SVH
`define SLIDING_WINDOW_HIT_COUNTER_MACROS_SVH

// Checked only while reset is released.
`define SWHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWHC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/swhc_pkg.sv
// Shared types and constants for the sliding window hit counter.
package swhc_pkg;

    localparam int STAMP_W    = 31;
    localparam int COUNT_W    = 24;
    localparam int TOTAL_W    = 33;
    localparam int WINDOW_DEF = 300;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Item opcodes
    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One bucket as held in memory
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HIT_RD,
        ST_HIT_WR,
        ST_SUM,
        ST_SUM_END,
        ST_OUT
    } t_state;

endpackage

### src/swhc_ram.sv
// Generic single write port, single read port RAM with registered read.
module swhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/swhc_mod.sv
// Remainder unit: stamp mod WINDOW by reciprocal multiplication.
module swhc_mod #(
    parameter int WINDOW = swhc_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [swhc_pkg::STAMP_W-1:0] i_value,
    output logic                        o_done,
    output logic [$clog2(WINDOW)-1:0]   o_rem
);

    localparam int AW    = $clog2(WINDOW);
    localparam int SHIFT = swhc_pkg::STAMP_W + AW;
    localparam int MW    = swhc_pkg::STAMP_W + 2;
    localparam int PW    = swhc_pkg::STAMP_W + MW;

    // ceil(2^SHIFT / WINDOW) gives the exact quotient for every stamp
    localparam logic [MW-1:0] MAGIC =
        MW'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic                         r_mul, n_mul;   // product stage busy
    logic                         r_fix, n_fix;   // correction stage busy
    logic [swhc_pkg::STAMP_W-1:0] r_val, n_val;
    logic [AW-1:0]                r_quo, n_quo;
    logic [AW-1:0]                r_rem, n_rem;
    logic [PW-1:0]                product;

    // Quotient from the reciprocal, then remainder in the low AW bits
    always_comb begin
        product = PW'(r_val) * PW'(MAGIC);
        n_mul   = i_start;
        n_fix   = r_mul;
        n_val   = r_val;
        n_quo   = r_quo;
        n_rem   = r_rem;
        if (i_start) begin
            n_val = i_value;
        end
        if (r_mul) begin
            n_quo = product[SHIFT +: AW];
        end
        if (r_fix) begin
            n_rem = r_val[AW-1:0] - AW'(r_quo * AW'(WINDOW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul <= 1'b0;
            r_fix <= 1'b0;
        end else begin
            r_mul <= n_mul;
            r_fix <= n_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    // Done in the correction cycle; remainder valid next cycle
    assign o_done = r_fix;
    assign o_rem  = r_rem;

endmodule

### src/sliding_window_hit_counter.sv
// Hit: remainder unit, then one bucket read and one write; the next item is taken after the write.
// Query: WINDOW bucket reads from one RAM read port, summed into the result; the next item is
// taken once the result enters the output register, later while the previous result is stalled.
// A finished result waits in the output register; a new item may be taken meanwhile.
// Reset is synchronous, active low; it starts a clearing pass over every bucket of the
// bucket RAM, during which o_in_stall stays high.
module sliding_window_hit_counter #(
    parameter int WINDOW = swhc_pkg::WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [swhc_pkg::STAMP_W-1:0] i_stamp,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [swhc_pkg::TOTAL_W-1:0] o_window_total
);

    localparam int AW = $clog2(WINDOW);
    localparam int EW = $bits(swhc_pkg::t_entry);

    swhc_pkg::t_state r_state, n_state;
    logic [AW-1:0]                r_idx, n_idx;
    logic [swhc_pkg::STAMP_W-1:0] r_stamp, n_stamp;
    logic [swhc_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                         r_pend, n_pend;
    logic                         r_out_valid, n_out_valid;
    logic [swhc_pkg::TOTAL_W-1:0] r_out_total, n_out_total;

    logic                 in_xfer;
    logic                 mod_start, mod_done;
    logic [AW-1:0]        slot;
    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    swhc_pkg::t_entry     wr_entry, rd_entry;
    logic [EW-1:0]        rd_data;
    logic                 in_window;
    logic [swhc_pkg::TOTAL_W:0] acc_sum;

    swhc_mod #(.WINDOW(WINDOW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_stamp),
        .o_done  (mod_done),
        .o_rem   (slot)
    );

    swhc_ram #(.WIDTH(EW), .DEPTH(WINDOW)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_entry = swhc_pkg::t_entry'(rd_data);
    assign in_xfer  = i_in_valid && !o_in_stall;

    // Bucket qualifies when stamp + WINDOW > query time
    assign in_window = ({1'b0, rd_entry.stamp} + 32'(WINDOW)) > {1'b0, r_stamp};

    // Saturating accumulate of the bucket read last cycle
    always_comb begin
        acc_sum = {1'b0, r_total};
        if (in_window) begin
            acc_sum = {1'b0, r_total} + (swhc_pkg::TOTAL_W+1)'(rd_entry.count);
        end
    end

    // Sequencer: clear, remainder, read-modify-write, sweep, output
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_stamp     = r_stamp;
        n_total     = r_total;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid;
        n_out_total = r_out_total;
        mod_start   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_entry    = '0;
        rd_en       = 1'b0;
        rd_addr     = r_idx;

        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (r_pend) begin
            if (acc_sum > {1'b0, swhc_pkg::TOTAL_MAX}) begin
                n_total = swhc_pkg::TOTAL_MAX;
            end else begin
                n_total = acc_sum[swhc_pkg::TOTAL_W-1:0];
            end
        end

        unique case (r_state)
            swhc_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == AW'(WINDOW - 1)) begin
                    n_idx   = '0;
                    n_state = swhc_pkg::ST_IDLE;
                end
            end
            swhc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_stamp = i_stamp;
                    if (i_op == swhc_pkg::OP_QUERY) begin
                        n_idx   = '0;
                        n_total = '0;
                        n_state = swhc_pkg::ST_SUM;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = swhc_pkg::ST_MOD;
                    end
                end
            end
            swhc_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_state = swhc_pkg::ST_HIT_RD;
                end
            end
            swhc_pkg::ST_HIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = slot;
                n_state = swhc_pkg::ST_HIT_WR;
            end
            swhc_pkg::ST_HIT_WR: begin
                wr_en   = 1'b1;
                wr_addr = slot;
                if (rd_entry.stamp != r_stamp) begin
                    wr_entry.stamp = r_stamp;
                    wr_entry.count = swhc_pkg::COUNT_W'(1);
                end else if (rd_entry.count != swhc_pkg::COUNT_MAX) begin
                    wr_entry.stamp = rd_entry.stamp;
                    wr_entry.count = rd_entry.count + 1'b1;
                end else begin
                    wr_entry = rd_entry;
                end
                n_state = swhc_pkg::ST_IDLE;
            end
            swhc_pkg::ST_SUM: begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == AW'(WINDOW - 1)) begin
                    n_idx   = '0;
                    n_state = swhc_pkg::ST_SUM_END;
                end
            end
            swhc_pkg::ST_SUM_END: begin
                n_state = swhc_pkg::ST_OUT;
            end
            swhc_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_total = r_total;
                    n_state     = swhc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swhc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swhc_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_stamp     <= n_stamp;
        r_total     <= n_total;
        r_out_total <= n_out_total;
    end

    assign o_in_stall     = (r_state != swhc_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_window_total = r_out_total;

endmodule

### src/swhc_checker.sv
// Port-level checker for the sliding window hit counter, bound to the top level.
`include "sliding_window_hit_counter_macros.svh"

module swhc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_op,
    input logic [swhc_pkg::STAMP_W-1:0] i_stamp,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [swhc_pkg::TOTAL_W-1:0] o_window_total
);

    // A stalled result holds
    `SWHC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_window_total), "result changed while stalled")

    // A stalled input transfer holds
    `SWHC_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_op) && $stable(i_stamp), "input changed while stalled")

    // Reset empties the output register
    `SWHC_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // Reset starts the clearing pass, so no item is taken straight after it
    `SWHC_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> o_in_stall, "input open during clearing pass")

    // Every item keeps the block busy straight after its transfer
    `SWHC_ASSERT(a_busy_after, i_in_valid && !o_in_stall |=> o_in_stall, "input open right after a transfer")

endmodule

bind sliding_window_hit_counter swhc_checker u_swhc_checker (.*);

### sim/sliding_window_hit_counter_tb.sv
// Self-checking testbench for the sliding window hit counter against a bucket model.
module sliding_window_hit_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAMP_W    = swhc_pkg::STAMP_W;
    localparam int COUNT_W    = swhc_pkg::COUNT_W;
    localparam int TOTAL_W    = swhc_pkg::TOTAL_W;
    localparam int WIN        = swhc_pkg::WINDOW_DEF;
    localparam int RST_CYCLES = 7;
    localparam int ITEMS      = 1250;
    localparam int LIMIT      = 3_000_000;
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef struct {
        logic               op;
        logic [STAMP_W-1:0] stamp;
        bit                 drain;   // hold back until every total has arrived
    } t_hit_item;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_op        = swhc_pkg::OP_HIT;
    logic [STAMP_W-1:0] i_stamp     = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [TOTAL_W-1:0] o_window_total;

    // Stimulus and expectations
    t_hit_item          pending_q[$];
    logic [TOTAL_W-1:0] expected_totals[$];

    // Shadow bucket ring
    logic [STAMP_W-1:0] ring_stamp[WIN];
    logic [COUNT_W-1:0] ring_count[WIN];

    int  cycle_cnt  = 0;
    int  rst_cnt    = 0;
    int  in_xfers   = 0;
    int  taken      = 0;
    int  made       = 0;
    int  n_hits     = 0;
    int  n_queries  = 0;
    int  n_checked  = 0;
    int  n_errors   = 0;
    logic calm;

    // No idling on either side for a stretch of the run
    assign calm = (in_xfers >= 500) && (in_xfers < 750);

    sliding_window_hit_counter #(
        .WINDOW(WIN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_stamp        (i_stamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_window_total (o_window_total)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bucket update for a hit
    function automatic void tally_hit(input logic [STAMP_W-1:0] stamp);
        int slot;
        slot = int'(longint'(stamp) % WIN);
        if (ring_stamp[slot] != stamp) begin
            ring_stamp[slot] = stamp;
            ring_count[slot] = COUNT_W'(1);
        end else if (ring_count[slot] != swhc_pkg::COUNT_MAX) begin
            ring_count[slot] = ring_count[slot] + 1'b1;
        end
    endfunction

    // Sum of every bucket whose stamp is no older than stamp-WIN+1
    function automatic logic [TOTAL_W-1:0] window_total_at(input logic [STAMP_W-1:0] stamp);
        longint sum;
        sum = 0;
        for (int i = 0; i < WIN; i++) begin
            if (longint'(ring_stamp[i]) + WIN > longint'(stamp))
                sum += longint'(ring_count[i]);
        end
        if (sum > longint'(swhc_pkg::TOTAL_MAX))
            sum = longint'(swhc_pkg::TOTAL_MAX);
        return sum[TOTAL_W-1:0];
    endfunction

    task automatic add_item(input logic op, input longint stamp, input bit drain);
        t_hit_item it;
        it.op    = op;
        it.stamp = stamp[STAMP_W-1:0];
        it.drain = drain;
        pending_q.push_back(it);
        made++;
    endtask

    // Reset, then present pending transfers at the falling edge
    always @(negedge i_clk) begin : feed
        logic      nxt_valid;
        t_hit_item it;
        nxt_valid = i_in_valid;
        if (rst_cnt < RST_CYCLES - 1) begin
            rst_cnt++;
            i_rst_n <= 1'b0;
        end else begin
            i_rst_n <= 1'b1;
            // retire the transfer taken at the last rising edge
            if (i_in_valid && in_xfers > taken) begin
                void'(pending_q.pop_front());
                taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_q.size() > 0) begin
                it = pending_q[0];
                if (it.drain && expected_totals.size() != 0) begin
                    nxt_valid = 1'b0;
                end else if (!calm && $urandom_range(99) < 33) begin
                    nxt_valid = 1'b0;
                end else begin
                    nxt_valid = 1'b1;
                    i_op    <= it.op;
                    i_stamp <= it.stamp;
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
    end

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_xfers++;
                if (i_op == swhc_pkg::OP_QUERY) begin
                    expected_totals.push_back(window_total_at(i_stamp));
                    n_queries++;
                end else begin
                    tally_hit(i_stamp);
                    n_hits++;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_totals.size() == 0) begin
                    $display("%0t: unexpected window total, expected none, got %0d",
                             $time, o_window_total);
                    n_errors++;
                end else begin
                    if (o_window_total !== expected_totals[0]) begin
                        $display("%0t: window_total mismatch, expected %0d, got %0d",
                                 $time, expected_totals[0], o_window_total);
                        n_errors++;
                    end
                    void'(expected_totals.pop_front());
                    n_checked++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("sliding_window_hit_counter verification failed");
        $finish;
    end

    initial begin : stimulus
        longint cur;
        int     len;
        int     pick;
        int     step;
        logic   op;

        for (int i = 0; i < WIN; i++) begin
            ring_stamp[i] = '0;
            ring_count[i] = '0;
        end

        // Hit at second zero straight after reset, early-time queries
        add_item(swhc_pkg::OP_HIT,   0, 0);
        add_item(swhc_pkg::OP_QUERY, 0, 0);
        add_item(swhc_pkg::OP_HIT,   0, 0);
        add_item(swhc_pkg::OP_HIT,   1, 0);
        add_item(swhc_pkg::OP_HIT,   5, 0);
        add_item(swhc_pkg::OP_QUERY, 5, 0);
        add_item(swhc_pkg::OP_QUERY, WIN - 2, 0);
        add_item(swhc_pkg::OP_QUERY, WIN - 1, 0);
        // Window edge, bucket zero reused with a new stamp
        add_item(swhc_pkg::OP_QUERY, WIN, 0);
        add_item(swhc_pkg::OP_HIT,   WIN, 0);
        add_item(swhc_pkg::OP_QUERY, WIN, 0);
        add_item(swhc_pkg::OP_HIT,   2 * WIN - 1, 0);
        add_item(swhc_pkg::OP_QUERY, 2 * WIN - 1, 0);
        add_item(swhc_pkg::OP_QUERY, 2 * WIN, 0);
        // Top of the stamp range
        add_item(swhc_pkg::OP_HIT,   longint'(STAMP_MAX) - 1, 0);
        add_item(swhc_pkg::OP_HIT,   longint'(STAMP_MAX), 0);
        add_item(swhc_pkg::OP_HIT,   longint'(STAMP_MAX), 0);
        add_item(swhc_pkg::OP_QUERY, longint'(STAMP_MAX), 0);
        // Time running backwards: future buckets still count
        add_item(swhc_pkg::OP_HIT,   1000, 1);
        add_item(swhc_pkg::OP_QUERY, 1000, 0);
        add_item(swhc_pkg::OP_QUERY, longint'(STAMP_MAX), 0);

        // Random sessions of mostly nondecreasing stamps from a random base
        while (made < ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 15)
                cur = $urandom_range(600);
            else if (pick < 30)
                cur = longint'(STAMP_MAX) - $urandom_range(1500);
            else
                cur = longint'({1'b0, $urandom()}) & longint'(STAMP_MAX);
            len = $urandom_range(80, 20);
            repeat (len) begin
                step = $urandom_range(99);
                if (step < 55)
                    cur = cur;
                else if (step < 82)
                    cur = cur + $urandom_range(5, 1);
                else if (step < 95)
                    cur = cur + $urandom_range(2 * WIN, 6);
                else
                    cur = cur - $urandom_range(WIN + 100, 1);
                if (cur < 0)
                    cur = 0;
                if (cur > longint'(STAMP_MAX))
                    cur = longint'(STAMP_MAX);
                op = ($urandom_range(99) < 35) ? swhc_pkg::OP_QUERY : swhc_pkg::OP_HIT;
                add_item(op, cur, (made % 250) == 0);
            end
        end

        // Drain: all transfers taken and every total back
        while (pending_q.size() != 0 || i_in_valid || expected_totals.size() != 0)
            @(posedge i_clk);
        repeat (WIN + 40) @(posedge i_clk);

        if (expected_totals.size() != 0) begin
            $display("%0t: %0d window totals never arrived", $time, expected_totals.size());
            n_errors++;
        end
        $display("Run covered %0d hits and %0d queries over early, wrapped and",
                 n_hits, n_queries);
        $display("top-of-range stamps; %0d window totals checked, %0d mismatches.",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("sliding_window_hit_counter verification clean");
        end else begin
            $display("sliding_window_hit_counter verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/swhc_pkg.sv
src/swhc_ram.sv
src/swhc_mod.sv
src/sliding_window_hit_counter.sv
src/swhc_checker.sv
sim/sliding_window_hit_counter_tb.sv
